@@ sv/psstd_pkg.sv @@
`timescale 1ns / 1ps
package psstd_pkg;

  // start strobe and saturation bound handed to one ratio lane
  typedef struct packed {
    logic        start;
    logic [31:0] cap;
  } ratio_ctl_t;

  localparam logic [31:0] CAP_SCALE     = 32'hFFFF_FFFF;
  localparam logic [31:0] CAP_SHIFT_NEG = 32'h8000_0000;
  localparam logic [31:0] CAP_SHIFT_POS = 32'h7FFF_FFFF;
  localparam logic [31:0] CAP_NORM_NEG  = 32'h0000_8000;
  localparam logic [31:0] CAP_NORM_POS  = 32'h0000_7FFF;

endpackage

@@ sv/psstd_ram.sv @@
`timescale 1ns / 1ps
module psstd_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/psstd_ratio.sv @@
`timescale 1ns / 1ps
// round(u / sqrt(d)) with ties away from zero, saturated at cap:
// w = floor(4*u*u / d), r = isqrt(w), result = (r + 1) / 2
module psstd_ratio #(
  parameter int U_W = 39,
  parameter int D_W = 46
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  psstd_pkg::ratio_ctl_t ctl_i,
  input  logic [U_W-1:0]        u_i,
  input  logic [D_W-1:0]        d_i,
  output logic [31:0]           m_o,
  output logic                  done_o
);

  localparam int W_W   = 2 * U_W + 2;
  localparam int R_W   = U_W + 1;
  localparam int CW    = $clog2(W_W + 1);
  localparam int CMP_W = (R_W > 32) ? R_W : 32;

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_SQR  = 3'd1;
  localparam logic [2:0] PH_DIV  = 3'd2;
  localparam logic [2:0] PH_ROOT = 3'd3;
  localparam logic [2:0] PH_FIN  = 3'd4;

  logic [2:0]       ph_q, ph_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [U_W-1:0]   us_q, us_d;
  logic [U_W-1:0]   um_q, um_d;
  logic [D_W-1:0]   dv_q, dv_d;
  logic [31:0]      cap_q, cap_d;
  logic [2*U_W-1:0] acc_q, acc_d;
  logic [W_W-1:0]   w_q, w_d;
  logic [D_W-1:0]   rem_q, rem_d;
  logic [R_W-1:0]   root_q, root_d;
  logic [R_W+1:0]   rr_q, rr_d;
  logic [31:0]      m_q, m_d;
  logic             done_q, done_d;

  logic [D_W:0]     rem_sh;
  logic [R_W+1:0]   rr_sh, trial;
  logic [R_W:0]     rnd;
  logic [CMP_W-1:0] m_ext, cap_ext;

  always_comb begin
    ph_d   = ph_q;
    cnt_d  = cnt_q;
    us_d   = us_q;
    um_d   = um_q;
    dv_d   = dv_q;
    cap_d  = cap_q;
    acc_d  = acc_q;
    w_d    = w_q;
    rem_d  = rem_q;
    root_d = root_q;
    rr_d   = rr_q;
    m_d    = m_q;
    done_d = 1'b0;
    rem_sh = {rem_q, w_q[W_W-1]};
    rr_sh  = {rr_q[R_W-1:0], w_q[W_W-1:W_W-2]};
    trial  = {root_q, 2'b01};
    rnd    = {1'b0, root_q} + (R_W+1)'(1);
    m_ext  = CMP_W'(rnd[R_W:1]);
    cap_ext = CMP_W'(cap_q);
    unique case (ph_q)
      PH_IDLE: begin
        if (ctl_i.start) begin
          us_d  = u_i;
          um_d  = u_i;
          dv_d  = d_i;
          cap_d = ctl_i.cap;
          acc_d = '0;
          cnt_d = CW'(U_W - 1);
          ph_d  = PH_SQR;
        end
      end
      PH_SQR: begin
        acc_d = {acc_q[2*U_W-2:0], 1'b0} + (us_q[U_W-1] ? (2*U_W)'(um_q) : '0);
        us_d  = {us_q[U_W-2:0], 1'b0};
        cnt_d = cnt_q - CW'(1);
        if (cnt_q == '0) begin
          w_d   = {acc_d, 2'b00};
          rem_d = '0;
          cnt_d = CW'(W_W - 1);
          ph_d  = PH_DIV;
        end
      end
      PH_DIV: begin
        // restoring division, quotient bits shift in behind the dividend
        if (rem_sh >= {1'b0, dv_q}) begin
          rem_d = D_W'(rem_sh - {1'b0, dv_q});
          w_d   = {w_q[W_W-2:0], 1'b1};
        end else begin
          rem_d = rem_sh[D_W-1:0];
          w_d   = {w_q[W_W-2:0], 1'b0};
        end
        cnt_d = cnt_q - CW'(1);
        if (cnt_q == '0) begin
          root_d = '0;
          rr_d   = '0;
          cnt_d  = CW'(W_W / 2 - 1);
          ph_d   = PH_ROOT;
        end
      end
      PH_ROOT: begin
        if (rr_sh >= trial) begin
          rr_d   = rr_sh - trial;
          root_d = {root_q[R_W-2:0], 1'b1};
        end else begin
          rr_d   = rr_sh;
          root_d = {root_q[R_W-2:0], 1'b0};
        end
        w_d   = {w_q[W_W-3:0], 2'b00};
        cnt_d = cnt_q - CW'(1);
        if (cnt_q == '0) begin
          ph_d = PH_FIN;
        end
      end
      PH_FIN: begin
        m_d    = (m_ext > cap_ext) ? cap_q : m_ext[31:0];
        done_d = 1'b1;
        ph_d   = PH_IDLE;
      end
      default: begin
        ph_d = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= PH_IDLE;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      ph_q   <= ph_d;
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    us_q   <= us_d;
    um_q   <= um_d;
    dv_q   <= dv_d;
    cap_q  <= cap_d;
    acc_q  <= acc_d;
    w_q    <= w_d;
    rem_q  <= rem_d;
    root_q <= root_d;
    rr_q   <= rr_d;
    m_q    <= m_d;
  end

  assign m_o    = m_q;
  assign done_o = done_q;

endmodule

@@ sv/point_set_standardizer_core.sv @@
`timescale 1ns / 1ps
// Points load one per cycle into an on-chip store while per-axis sums and
// square sums build up; an item with set_end closes the set. The block then
// takes the set's variance term in states S_NQ and S_DIFF, and three ratio
// lanes (one per axis, each squaring, dividing and taking a square root one
// bit a cycle) compute the scales, then the offsets, then each stored point
// in turn, so a set of n points takes n+2 lane passes; input is stalled
// from set_end until the last result has been handed to the output register.
module point_set_standardizer_core #(
  parameter int MAX_POINTS = 64,
  parameter int COORD_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] coord_x_i,
  input  logic signed [15:0] coord_y_i,
  input  logic signed [15:0] coord_z_i,
  input  logic               set_end_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] norm_x_o,
  output logic signed [15:0] norm_y_o,
  output logic signed [15:0] norm_z_o,
  output logic [31:0]        scale_x_o,
  output logic [31:0]        scale_y_o,
  output logic [31:0]        scale_z_o,
  output logic signed [31:0] shift_x_o,
  output logic signed [31:0] shift_y_o,
  output logic signed [31:0] shift_z_o,
  output logic [2:0]         flat_axes_o,
  output logic               run_end_o
);

  localparam int CB    = COORD_BITS;
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int AW    = $clog2(MAX_POINTS);
  localparam int SUM_W = CB + CNT_W;
  localparam int SQ_W  = 2 * CB + CNT_W;
  localparam int D_W   = SQ_W + CNT_W;
  localparam int NUM_W = SUM_W + 2;
  localparam int U_W   = SUM_W + 16;

  localparam logic [3:0] S_LOAD   = 4'd0;
  localparam logic [3:0] S_NQ     = 4'd1;
  localparam logic [3:0] S_DIFF   = 4'd2;
  localparam logic [3:0] S_SCL_GO = 4'd3;
  localparam logic [3:0] S_SCL_WT = 4'd4;
  localparam logic [3:0] S_SHF_GO = 4'd5;
  localparam logic [3:0] S_SHF_WT = 4'd6;
  localparam logic [3:0] S_RD     = 4'd7;
  localparam logic [3:0] S_NUM    = 4'd8;
  localparam logic [3:0] S_PT_GO  = 4'd9;
  localparam logic [3:0] S_PT_WT  = 4'd10;
  localparam logic [3:0] S_PUT    = 4'd11;

  logic [3:0]              state_q, state_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic [CNT_W-1:0]        k_q, k_d;
  logic signed [SUM_W-1:0] sum_q [3];
  logic signed [SUM_W-1:0] sum_d [3];
  logic [SQ_W-1:0]         sq_q [3];
  logic [SQ_W-1:0]         sq_d [3];
  logic [D_W-1:0]          nq_q [3];
  logic [D_W-1:0]          nq_d [3];
  logic [D_W-1:0]          ss_q [3];
  logic [D_W-1:0]          ss_d [3];
  logic [D_W-1:0]          dev_q [3];
  logic [D_W-1:0]          dev_d [3];
  logic [2:0]              flat_q, flat_d;
  logic [31:0]             scale_q [3];
  logic [31:0]             scale_d [3];
  logic [31:0]             shift_q [3];
  logic [31:0]             shift_d [3];
  logic signed [NUM_W-1:0] num_q [3];
  logic signed [NUM_W-1:0] num_d [3];
  logic [15:0]             res_q [3];
  logic [15:0]             res_d [3];
  logic                    last_q, last_d;
  logic                    out_valid_q, out_valid_d;
  logic [15:0]             onorm_q [3];
  logic [15:0]             onorm_d [3];
  logic [31:0]             oscale_q [3];
  logic [31:0]             oscale_d [3];
  logic [31:0]             oshift_q [3];
  logic [31:0]             oshift_d [3];
  logic [2:0]              oflat_q, oflat_d;
  logic                    orun_q, orun_d;

  logic                    in_acc;
  logic                    store_we;
  logic                    store_re;
  logic [3*CB-1:0]         store_wdata, store_rdata;
  logic signed [CB-1:0]    vin [3];
  logic [CB+15:0]          pad [3];
  logic [15:0]             cin [3];

  psstd_pkg::ratio_ctl_t   ctl [3];
  logic [U_W-1:0]          lane_u [3];
  logic [31:0]             lane_m [3];
  logic                    lane_done [3];

  assign cin[0] = coord_x_i;
  assign cin[1] = coord_y_i;
  assign cin[2] = coord_z_i;

  // low COORD_BITS of the port, zero above bit 15 when the coordinate is wider
  for (genvar a = 0; a < 3; a++) begin : g_in
    assign pad[a] = {{CB{1'b0}}, cin[a]};
    assign vin[a] = $signed(pad[a][CB-1:0]);
  end

  assign in_stall_o  = (state_q != S_LOAD);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign store_we    = in_acc && (cnt_q < CNT_W'(MAX_POINTS));
  assign store_wdata = {vin[2], vin[1], vin[0]};
  assign store_re    = (state_q == S_RD);

  psstd_ram #(
    .WIDTH (3 * CB),
    .DEPTH (MAX_POINTS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .waddr_i (cnt_q[AW-1:0]),
    .wdata_i (store_wdata),
    .re_i    (store_re),
    .raddr_i (k_q[AW-1:0]),
    .rdata_o (store_rdata)
  );

  for (genvar a = 0; a < 3; a++) begin : g_lane
    logic [SUM_W-1:0] smag;
    logic [NUM_W-1:0] nmag;
    always_comb begin
      smag = sum_q[a][SUM_W-1] ? SUM_W'(-sum_q[a]) : SUM_W'(sum_q[a]);
      nmag = num_q[a][NUM_W-1] ? NUM_W'(-num_q[a]) : NUM_W'(num_q[a]);
      ctl[a].start = (state_q == S_SCL_GO) || (state_q == S_SHF_GO) ||
                     (state_q == S_PT_GO);
      if (state_q == S_SCL_GO || state_q == S_SCL_WT) begin
        lane_u[a]  = {SUM_W'(cnt_q), 16'h0000};
        ctl[a].cap = psstd_pkg::CAP_SCALE;
      end else if (state_q == S_SHF_GO || state_q == S_SHF_WT) begin
        lane_u[a]  = {smag, 16'h0000};
        // offset is minus the sum, so a positive sum gives a negative offset
        ctl[a].cap = (!sum_q[a][SUM_W-1] && sum_q[a] != '0) ?
                     psstd_pkg::CAP_SHIFT_NEG : psstd_pkg::CAP_SHIFT_POS;
      end else begin
        lane_u[a]  = {4'h0, nmag[SUM_W-1:0], 12'h000};
        ctl[a].cap = num_q[a][NUM_W-1] ? psstd_pkg::CAP_NORM_NEG :
                     psstd_pkg::CAP_NORM_POS;
      end
    end

    psstd_ratio #(
      .U_W (U_W),
      .D_W (D_W)
    ) u_ratio (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl[a]),
      .u_i    (lane_u[a]),
      .d_i    (dev_q[a]),
      .m_o    (lane_m[a]),
      .done_o (lane_done[a])
    );
  end

  always_comb begin
    logic signed [2*SUM_W-1:0] sprod;
    logic signed [CB-1:0]      vs;
    logic signed [2*CB-1:0]    vsq;
    logic signed [NUM_W-1:0]   nv;
    logic                      take;
    state_d     = state_q;
    cnt_d       = cnt_q;
    k_d         = k_q;
    flat_d      = flat_q;
    last_d      = last_q;
    out_valid_d = out_valid_q;
    oflat_d     = oflat_q;
    orun_d      = orun_q;
    sprod       = '0;
    vs          = '0;
    vsq         = '0;
    nv          = '0;
    for (int a = 0; a < 3; a++) begin
      sum_d[a]    = sum_q[a];
      sq_d[a]     = sq_q[a];
      nq_d[a]     = nq_q[a];
      ss_d[a]     = ss_q[a];
      dev_d[a]    = dev_q[a];
      scale_d[a]  = scale_q[a];
      shift_d[a]  = shift_q[a];
      num_d[a]    = num_q[a];
      res_d[a]    = res_q[a];
      onorm_d[a]  = onorm_q[a];
      oscale_d[a] = oscale_q[a];
      oshift_d[a] = oshift_q[a];
    end
    take = out_valid_q && !out_stall_i;
    if (take) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_LOAD: begin
        if (store_we) begin
          for (int a = 0; a < 3; a++) begin
            vsq      = vin[a] * vin[a];
            sum_d[a] = sum_q[a] + SUM_W'(vin[a]);
            sq_d[a]  = sq_q[a] + SQ_W'($unsigned(vsq));
          end
          cnt_d = cnt_q + CNT_W'(1);
        end
        if (in_acc && set_end_i) begin
          state_d = S_NQ;
        end
      end
      S_NQ: begin
        for (int a = 0; a < 3; a++) begin
          sprod    = sum_q[a] * sum_q[a];
          nq_d[a]  = D_W'(cnt_q) * D_W'(sq_q[a]);
          ss_d[a]  = $unsigned(sprod);
        end
        state_d = S_DIFF;
      end
      S_DIFF: begin
        for (int a = 0; a < 3; a++) begin
          dev_d[a]  = nq_q[a] - ss_q[a];
          flat_d[a] = (nq_q[a] == ss_q[a]);
        end
        state_d = S_SCL_GO;
      end
      S_SCL_GO: begin
        state_d = S_SCL_WT;
      end
      S_SCL_WT: begin
        if (lane_done[0]) begin
          for (int a = 0; a < 3; a++) begin
            scale_d[a] = flat_q[a] ? '0 : lane_m[a];
          end
          state_d = S_SHF_GO;
        end
      end
      S_SHF_GO: begin
        state_d = S_SHF_WT;
      end
      S_SHF_WT: begin
        if (lane_done[0]) begin
          for (int a = 0; a < 3; a++) begin
            if (flat_q[a]) begin
              shift_d[a] = '0;
            end else if (!sum_q[a][SUM_W-1] && sum_q[a] != '0) begin
              shift_d[a] = 32'h0 - lane_m[a];
            end else begin
              shift_d[a] = lane_m[a];
            end
          end
          k_d     = '0;
          state_d = S_RD;
        end
      end
      S_RD: begin
        state_d = S_NUM;
      end
      S_NUM: begin
        for (int a = 0; a < 3; a++) begin
          vs       = $signed(store_rdata[a*CB +: CB]);
          nv       = NUM_W'($signed({1'b0, cnt_q})) * NUM_W'(vs);
          num_d[a] = nv - NUM_W'(sum_q[a]);
        end
        last_d  = (k_q == cnt_q - CNT_W'(1));
        state_d = S_PT_GO;
      end
      S_PT_GO: begin
        state_d = S_PT_WT;
      end
      S_PT_WT: begin
        if (lane_done[0]) begin
          for (int a = 0; a < 3; a++) begin
            if (flat_q[a]) begin
              res_d[a] = '0;
            end else if (num_q[a][NUM_W-1]) begin
              res_d[a] = 16'h0 - lane_m[a][15:0];
            end else begin
              res_d[a] = lane_m[a][15:0];
            end
          end
          state_d = S_PUT;
        end
      end
      S_PUT: begin
        if (!out_valid_q || take) begin
          for (int a = 0; a < 3; a++) begin
            onorm_d[a]  = res_q[a];
            oscale_d[a] = scale_q[a];
            oshift_d[a] = shift_q[a];
          end
          oflat_d     = flat_q;
          orun_d      = last_q;
          out_valid_d = 1'b1;
          if (last_q) begin
            for (int a = 0; a < 3; a++) begin
              sum_d[a] = '0;
              sq_d[a]  = '0;
            end
            cnt_d   = '0;
            state_d = S_LOAD;
          end else begin
            k_d     = k_q + CNT_W'(1);
            state_d = S_RD;
          end
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      cnt_q       <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
      for (int a = 0; a < 3; a++) begin
        sum_q[a] <= '0;
        sq_q[a]  <= '0;
      end
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
      for (int a = 0; a < 3; a++) begin
        sum_q[a] <= sum_d[a];
        sq_q[a]  <= sq_d[a];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    flat_q  <= flat_d;
    last_q  <= last_d;
    oflat_q <= oflat_d;
    orun_q  <= orun_d;
    for (int a = 0; a < 3; a++) begin
      nq_q[a]     <= nq_d[a];
      ss_q[a]     <= ss_d[a];
      dev_q[a]    <= dev_d[a];
      scale_q[a]  <= scale_d[a];
      shift_q[a]  <= shift_d[a];
      num_q[a]    <= num_d[a];
      res_q[a]    <= res_d[a];
      onorm_q[a]  <= onorm_d[a];
      oscale_q[a] <= oscale_d[a];
      oshift_q[a] <= oshift_d[a];
    end
  end

  assign out_valid_o = out_valid_q;
  assign norm_x_o    = onorm_q[0];
  assign norm_y_o    = onorm_q[1];
  assign norm_z_o    = onorm_q[2];
  assign scale_x_o   = oscale_q[0];
  assign scale_y_o   = oscale_q[1];
  assign scale_z_o   = oscale_q[2];
  assign shift_x_o   = oshift_q[0];
  assign shift_y_o   = oshift_q[1];
  assign shift_z_o   = oshift_q[2];
  assign flat_axes_o = oflat_q;
  assign run_end_o   = orun_q;

endmodule

@@ sv/psstd_checker.sv @@
`timescale 1ns / 1ps
module psstd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        set_end_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [15:0] norm_x_o,
  input logic [31:0] scale_x_o,
  input logic [31:0] shift_x_o,
  input logic [2:0]  flat_axes_o
);

  // a held item keeps its x norm and x scale
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(norm_x_o) &&
    $stable(scale_x_o))
    else $error("held output item changed");

  // a flat x axis carries zeros in its norm, scale and shift fields
  a_flat_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && flat_axes_o[0] |->
    norm_x_o == '0 && scale_x_o == '0 && shift_x_o == '0)
    else $error("flat x axis with nonzero fields");

  // the end of a set stops input while the set is computed
  a_end_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && set_end_i |=> in_stall_o)
    else $error("input taken right after end of set");

endmodule

bind point_set_standardizer_core psstd_checker u_psstd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .set_end_i   (set_end_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .norm_x_o    (norm_x_o),
  .scale_x_o   (scale_x_o),
  .shift_x_o   (shift_x_o),
  .flat_axes_o (flat_axes_o)
);

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;

  localparam int NPTS = 64;

  typedef struct {
    logic [15:0] norm [3];
    logic [31:0] scale [3];
    logic [31:0] shift [3];
    logic [2:0]  flat;
    logic        last;
  } std_point_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  logic signed [15:0] coord_x_i, coord_y_i, coord_z_i;
  logic set_end_i;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [15:0] norm_x_o, norm_y_o, norm_z_o;
  logic [31:0] scale_x_o, scale_y_o, scale_z_o;
  logic signed [31:0] shift_x_o, shift_y_o, shift_z_o;
  logic [2:0] flat_axes_o;
  logic run_end_o;

  point_set_standardizer_core dut (.*);

  always #5 clk_i = ~clk_i;

  // predictor state
  longint pt_store [NPTS][3];
  longint ax_sum [3];
  longint ax_sq [3];
  int     pt_cnt;

  std_point_t std_q [$];
  int errors;
  int sent;
  int burst_left;

  // round(u / sqrt(d)) ties away from zero, capped
  function automatic logic [63:0] root_ratio(logic [127:0] u, logic [127:0] d,
                                             logic [63:0] cap);
    logic [63:0] lo, hi, mid;
    logic [127:0] t;
    lo = 0;
    hi = cap;
    while (lo < hi) begin
      mid = lo + (hi - lo + 1) / 2;
      t = 2 * {64'd0, mid} - 1;
      if (t * t * d <= 4 * u * u) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  function automatic logic [31:0] signed_ratio(longint num, int frac, longint d, int width);
    logic neg;
    logic [127:0] mag;
    logic [63:0] cap, m;
    neg = num < 0;
    mag = neg ? -num : num;
    cap = neg ? (64'd1 << (width - 1)) : (64'd1 << (width - 1)) - 1;
    m = root_ratio(mag << frac, d, cap);
    if (neg) m = -m;
    if (width == 16) return {16'd0, m[15:0]};
    return m[31:0];
  endfunction

  task automatic standardize_point(longint v [3], logic end_flag);
    longint dev [3];
    std_point_t r;
    logic [31:0] sc [3], sh [3];
    logic [2:0] fl;
    longint n;
    if (pt_cnt < NPTS) begin
      for (int a = 0; a < 3; a++) begin
        pt_store[pt_cnt][a] = v[a];
        ax_sum[a] += v[a];
        ax_sq[a] += v[a] * v[a];
      end
      pt_cnt++;
    end
    if (!end_flag) return;
    n = pt_cnt;
    fl = 0;
    for (int a = 0; a < 3; a++) begin
      dev[a] = n * ax_sq[a] - ax_sum[a] * ax_sum[a];
      if (dev[a] == 0) begin
        fl[a] = 1'b1;
        sc[a] = 0;
        sh[a] = 0;
      end else begin
        sc[a] = root_ratio({64'd0, n} << 16, dev[a], psstd_pkg::CAP_SCALE);
        sh[a] = signed_ratio(-ax_sum[a], 16, dev[a], 32);
      end
    end
    for (int k = 0; k < pt_cnt; k++) begin
      for (int a = 0; a < 3; a++) begin
        r.norm[a] = (dev[a] == 0) ? 16'd0 :
                    16'(signed_ratio(n * pt_store[k][a] - ax_sum[a], 12, dev[a], 16));
        r.scale[a] = sc[a];
        r.shift[a] = sh[a];
      end
      r.flat = fl;
      r.last = (k + 1 == pt_cnt);
      std_q.insert(std_q.size(), r);
    end
    for (int a = 0; a < 3; a++) begin
      ax_sum[a] = 0;
      ax_sq[a] = 0;
    end
    pt_cnt = 0;
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // sends one item, returns after it has been accepted
  task automatic send_point(logic signed [15:0] x, logic signed [15:0] y,
                            logic signed [15:0] z, logic end_flag);
    longint v [3];
    in_valid_i <= 1'b1;
    coord_x_i <= x;
    coord_y_i <= y;
    coord_z_i <= z;
    set_end_i <= end_flag;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    v[0] = x;
    v[1] = y;
    v[2] = z;
    standardize_point(v, end_flag);
    sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(0, 8);
    end
  endtask

  function automatic logic signed [15:0] rand_coord(int mode);
    case (mode)
      0: return 16'($urandom);
      1: return $signed(16'($urandom_range(0, 200))) - 16'sd100;
      default: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
    endcase
  endfunction

  task automatic send_set(int size, int mode);
    for (int i = 0; i < size; i++)
      send_point(rand_coord(mode), rand_coord(mode), rand_coord(mode), i == size - 1);
  endtask

  task automatic test_directed();
    send_point(16'sh7fff, -16'sd5, 16'sh8000, 1'b1);  // single point, all flat
    send_point(16'sh7fff, 16'sh7fff, 16'sd0, 1'b0);
    send_point(16'sh8000, 16'sh7fff, 16'sd1, 1'b1);   // y flat
    send_point(16'sh5555, 16'shaaaa, 16'sh8000, 1'b0);
    send_point(16'shaaaa, 16'sh5555, 16'sh8000, 1'b0);
    send_point(16'sh0000, 16'shffff, 16'sh8000, 1'b1); // z flat at minimum
    send_set(3, 2);
    send_set(4, 1);
    in_valid_i <= 1'b0;
    wait (std_q.size() == 0);
  endtask

  // overflowing set: the points past the store size are dropped
  task automatic test_store_full();
    send_set(NPTS + 2, 0);
    send_point(16'sd3, 16'sd3, 16'sd3, 1'b0);
    send_point(-16'sd3, 16'sd3, 16'sd9, 1'b1);
  endtask

  task automatic test_random();
    int mode;
    while (sent < 360) begin
      mode = ($urandom_range(0, 9) == 0) ? 2 : $urandom_range(0, 1);
      case ($urandom_range(0, 19))
        0: send_set(1, mode);
        1: send_set(NPTS, 0);
        default: send_set($urandom_range(2, 10), mode);
      endcase
      if ($urandom_range(0, 7) == 0) begin
        in_valid_i <= 1'b0;
        wait (std_q.size() == 0);
        @(posedge clk_i);
      end
    end
  endtask

  // receiver
  int stall_mode = 0;
  int stall_left = 0;
  always @(posedge clk_i) begin
    std_point_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (std_q.size() == 0) begin
        report_mismatch("unexpected item", 0, 0);
      end else begin
        e = std_q.pop_front();
        if (norm_x_o !== e.norm[0]) report_mismatch("norm_x", norm_x_o, e.norm[0]);
        if (norm_y_o !== e.norm[1]) report_mismatch("norm_y", norm_y_o, e.norm[1]);
        if (norm_z_o !== e.norm[2]) report_mismatch("norm_z", norm_z_o, e.norm[2]);
        if (scale_x_o !== e.scale[0]) report_mismatch("scale_x", scale_x_o, e.scale[0]);
        if (scale_y_o !== e.scale[1]) report_mismatch("scale_y", scale_y_o, e.scale[1]);
        if (scale_z_o !== e.scale[2]) report_mismatch("scale_z", scale_z_o, e.scale[2]);
        if (shift_x_o !== e.shift[0]) report_mismatch("shift_x", shift_x_o, e.shift[0]);
        if (shift_y_o !== e.shift[1]) report_mismatch("shift_y", shift_y_o, e.shift[1]);
        if (shift_z_o !== e.shift[2]) report_mismatch("shift_z", shift_z_o, e.shift[2]);
        if (flat_axes_o !== e.flat) report_mismatch("flat_axes", flat_axes_o, e.flat);
        if (run_end_o !== e.last) report_mismatch("run_end", run_end_o, e.last);
      end
    end
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(50, 400);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 3) == 0);
      2: out_stall_i <= ($urandom_range(0, 1) == 0);
      default: out_stall_i <= ($urandom_range(0, 7) != 0);
    endcase
  end

  initial begin
    errors = 0;
    sent = 0;
    burst_left = 0;
    pt_cnt = 0;
    for (int a = 0; a < 3; a++) begin
      ax_sum[a] = 0;
      ax_sq[a] = 0;
    end
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    coord_x_i <= '0;
    coord_y_i <= '0;
    coord_z_i <= '0;
    set_end_i <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_store_full();
    test_random();
    in_valid_i <= 1'b0;
    wait (std_q.size() == 0);
    repeat (400) @(posedge clk_i);
    if (errors == 0) $display("point_set_standardizer_core verification clean");
    else $display("point_set_standardizer_core verification failed");
    $finish;
  end

  initial begin
    #40ms;
    $display("point_set_standardizer_core verification failed");
    $finish;
  end

endmodule
